// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the Hijri date converter.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/hijri_pkg.sv =====
// Constants and helpers for the Hijri date converter.
// No dependencies.
package hijri_pkg;

  localparam int DN_W    = 22;
  localparam int YEAR_W  = 14;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int MD_W    = 19;   // thousandths of a day within one year

  localparam logic [DN_W-1:0] EPOCH_RESET = 22'd1948440;

  // Mean year length in thousandths of a day.
  localparam logic [MD_W-1:0] YEAR_MD        = 19'd354367;
  localparam logic [MD_W-1:0] COMMON_YEAR_MD = 19'd354000;
  localparam logic [9:0]      MILLI          = 10'd1000;

  // floor(2^32 * 1000 / 354367): quotient estimate is exact or one low.
  localparam logic [23:0] YEAR_RECIP  = 24'd12120110;
  // ceil(2^20 / 30): exact floor(y / 30) for y below 2^14.
  localparam logic [15:0] MOD30_RECIP = 16'd34953;
  // ceil(2^25 / 1000): exact floor(x / 1000) for x below 30000.
  localparam logic [15:0] DAY_RECIP   = 16'd33555;

  // First thousandth of each month in the year.
  localparam logic [MD_W-1:0] MONTH_START [12] = '{
    19'd0,      19'd30000,  19'd59000,  19'd89000,
    19'd118000, 19'd148000, 19'd177000, 19'd207000,
    19'd236000, 19'd266000, 19'd295000, 19'd325000
  };

  // Leap test on the position of a year in the 30-year cycle.
  function automatic logic is_leap(input logic [4:0] cyc);
    logic res;
    case (cyc)
      5'd2, 5'd5, 5'd7, 5'd10, 5'd13, 5'd16,
      5'd18, 5'd21, 5'd24, 5'd26, 5'd29: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/hijri_date_from_day_number.sv =====
// Hijri date converter: Julian day number in, tabular Islamic date out.
// Depends on hijri_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Converts one Julian day number per clock into a Hijri day, month, year and
// leap flag on the tabular Islamic calendar. The input channel and the result
// channel use valid/stall; while the result side does not stall, an item enters
// in every cycle, so sustained throughput is one item per clock. The depth
// is set by the two multiplier stages of the year division (reciprocal, then
// back-multiply), the correction stage, the mod-30 multiplier for the leap
// test and the day-of-month reciprocal in the output stage. The whole pipeline
// advances as one: a stall on the result side freezes every stage and is
// passed straight back as in_stall, so nothing is lost or repeated. The year
// is floor((jdn - epoch) / 354.367) + 1, kept exactly in thousandths of a
// day, or one more where the fraction past a common year rolls over; a day
// number before the epoch yields status_code 1 with all date fields zero. The
// epoch register resets to 1948440 and may be rewritten through the
// configuration channel (always ready) while the pipeline is empty.
module hijri_date_from_day_number
  import hijri_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [DN_W-1:0]     epoch_day_number,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DN_W-1:0]     julian_day_number,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DAY_W-1:0]    hijri_day,
  output logic [MONTH_W-1:0]  hijri_month,
  output logic [YEAR_W-1:0]   hijri_year,
  output logic                leap_year_flag,
  output logic                status_code
);

  // Global advance: hold every stage while the result waits.
  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Epoch register.
  logic [DN_W-1:0] epoch;
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= EPOCH_RESET;
    end else if (cfg_valid) begin
      epoch <= epoch_day_number;
    end
  end

  // Stage 1: days since epoch, flag dates before it.
  logic [DN_W:0]   s1_diff_next;
  logic            s1_valid, s1_err;
  logic [DN_W-1:0] s1_d;
  assign s1_diff_next = {1'b0, julian_day_number} - {1'b0, epoch};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err <= s1_diff_next[DN_W];
      s1_d   <= s1_diff_next[DN_W-1:0];
    end
  end

  // Stage 2: quotient estimate by reciprocal, days scaled to thousandths.
  logic [45:0]       s2_prod_next;
  logic [31:0]       s2_dm_next;
  logic              s2_valid, s2_err;
  logic [YEAR_W-1:0] s2_q;
  logic [31:0]       s2_dm;
  assign s2_prod_next = 46'(s1_d) * 46'(YEAR_RECIP);
  assign s2_dm_next   = 32'(s1_d) * 32'(MILLI);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_err <= s1_err;
      s2_q   <= s2_prod_next[45:32];
      s2_dm  <= s2_dm_next;
    end
  end

  // Stage 3: back-multiply the estimate.
  logic              s3_valid, s3_err;
  logic [YEAR_W-1:0] s3_q;
  logic [31:0]       s3_dm, s3_qm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_err <= s2_err;
      s3_q   <= s2_q;
      s3_dm  <= s2_dm;
      s3_qm  <= 32'(s2_q) * 32'(YEAR_MD);
    end
  end

  // Stage 4: remainder and one-step correction of the quotient.
  logic [31:0]       s4_diff_next;
  logic [MD_W:0]     s4_rem0_next;
  logic              s4_fix_next;
  logic              s4_valid, s4_err;
  logic [YEAR_W-1:0] s4_year;
  logic [MD_W-1:0]   s4_rem;
  assign s4_diff_next = s3_dm - s3_qm;
  assign s4_rem0_next = s4_diff_next[MD_W:0];
  assign s4_fix_next  = (s4_rem0_next >= (MD_W+1)'(YEAR_MD));

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_err <= s3_err;
      if (s4_fix_next) begin
        s4_year <= s3_q + YEAR_W'(2);
        s4_rem  <= MD_W'(s4_rem0_next - (MD_W+1)'(YEAR_MD));
      end else begin
        s4_year <= s3_q + YEAR_W'(1);
        s4_rem  <= s4_rem0_next[MD_W-1:0];
      end
    end
  end

  // Stage 5: year times reciprocal of 30 for the cycle position.
  logic              s5_valid, s5_err;
  logic [YEAR_W-1:0] s5_year;
  logic [MD_W-1:0]   s5_rem;
  logic [29:0]       s5_ymul;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_err  <= s4_err;
      s5_year <= s4_year;
      s5_rem  <= s4_rem;
      s5_ymul <= 30'(s4_year) * 30'(MOD30_RECIP);
    end
  end

  // Stage 6: leap test and month walk as parallel compares.
  logic [8:0]        s6_q30_next;
  logic [YEAR_W-1:0] s6_r14_next;
  logic [4:0]        s6_cyc_next, s6_cyc_nx_next;
  logic [3:0]        s6_idx_next;
  logic [MD_W-1:0]   s6_offs_full_next;
  logic              s6_leap_next, s6_leap_nx_next, s6_ovf_next;
  logic              s6_valid, s6_err, s6_ovf, s6_leap, s6_leap_nx;
  logic [YEAR_W-1:0] s6_year;
  logic [MONTH_W-1:0] s6_month;
  logic [14:0]       s6_offs;

  always_comb begin
    s6_q30_next    = s5_ymul[28:20];
    s6_r14_next    = s5_year - YEAR_W'(s6_q30_next) * YEAR_W'(30);
    s6_cyc_next    = s6_r14_next[4:0];
    s6_cyc_nx_next = (s6_cyc_next == 5'd29) ? 5'd0 : s6_cyc_next + 5'd1;
    s6_leap_next    = is_leap(s6_cyc_next);
    s6_leap_nx_next = is_leap(s6_cyc_nx_next);
    s6_idx_next = 4'd0;
    for (int i = 1; i < 12; i++) begin
      s6_idx_next = s6_idx_next + 4'(s5_rem >= MONTH_START[i]);
    end
    s6_offs_full_next = s5_rem - MONTH_START[s6_idx_next];
    // Common year past day 354: roll into the next year.
    s6_ovf_next = !s6_leap_next && (s5_rem >= COMMON_YEAR_MD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_err     <= s5_err;
      s6_ovf     <= s6_ovf_next;
      s6_leap    <= s6_leap_next;
      s6_leap_nx <= s6_leap_nx_next;
      s6_year    <= s5_year;
      s6_month   <= s6_idx_next + MONTH_W'(1);
      s6_offs    <= s6_offs_full_next[14:0];
    end
  end

  // Stage 7: day of month by reciprocal of 1000, output register.
  logic [29:0] s7_dmul_next;
  assign s7_dmul_next = 30'(s6_offs) * 30'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s6_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s6_err) begin
        hijri_day      <= '0;
        hijri_month    <= '0;
        hijri_year     <= '0;
        leap_year_flag <= 1'b0;
        status_code    <= 1'b1;
      end else if (s6_ovf) begin
        hijri_day      <= DAY_W'(1);
        hijri_month    <= MONTH_W'(1);
        hijri_year     <= s6_year + YEAR_W'(1);
        leap_year_flag <= s6_leap_nx;
        status_code    <= 1'b0;
      end else begin
        hijri_day      <= s7_dmul_next[29:25] + DAY_W'(1);
        hijri_month    <= s6_month;
        hijri_year     <= s6_year;
        leap_year_flag <= s6_leap;
        status_code    <= 1'b0;
      end
    end
  end

  // Checks
  `ASSERT_IMPL(a_rem_below_year, s4_valid && !s4_err, s4_rem < YEAR_MD)
  `ASSERT_IMPL(a_err_zero, out_valid && status_code,
               hijri_day == '0 && hijri_month == '0 && hijri_year == '0 && !leap_year_flag)
  `ASSERT_IMPL(a_ok_range, out_valid && !status_code,
               hijri_month != '0 && hijri_month <= MONTH_W'(12) &&
               hijri_day != '0 && hijri_day <= DAY_W'(30) && hijri_year != '0)
  `ASSERT_NEXT(a_s6_moves_out, adv && s6_valid, out_valid)

endmodule

// ===== test/hijri_date_checker.sv =====
// Result checker for the Hijri date converter: watches the epoch, input and result channels,
// predicts every date and compares it with what the block returns.
// Depends on hijri_pkg; instantiated beside the block by hijri_date_from_day_number_tb.
module hijri_date_checker
  import hijri_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [DN_W-1:0]    epoch_day_number,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [DN_W-1:0]    julian_day_number,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [DAY_W-1:0]   hijri_day,
  input  logic [MONTH_W-1:0] hijri_month,
  input  logic [YEAR_W-1:0]  hijri_year,
  input  logic               leap_year_flag,
  input  logic               status_code,
  output int                 mismatch_count,
  output int                 pending_dates,
  output int                 dates_checked,
  output int                 before_epoch_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned MEAN_YEAR_MD = 354367;  // thousandths of a day
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               leap;
    logic               status;
  } hijri_date_t;

  typedef struct {
    logic [DN_W-1:0] jdn;
    hijri_date_t     date;
  } pending_date_t;

  pending_date_t   expected_dates[$];
  logic [DN_W-1:0] epoch_copy = EPOCH_RESET;
  int              errors = 0;
  int              checked = 0;
  int              early = 0;

  function automatic bit cycle_leap(longint unsigned year);
    return (year % 30) inside {2, 5, 7, 10, 13, 16, 18, 21, 24, 26, 29};
  endfunction

  function automatic hijri_date_t convert_day_number(logic [DN_W-1:0] jdn,
                                                     logic [DN_W-1:0] epoch);
    hijri_date_t     r;
    longint unsigned span_md, year, rem, month_md;
    bit              walk_leap, placed;
    r = '0;
    if (jdn < epoch) begin
      r.status = 1'b1;
      return r;
    end
    span_md = jdn;
    span_md = (span_md - epoch) * 1000;
    year = span_md / MEAN_YEAR_MD + 1;
    rem = span_md - (year - 1) * MEAN_YEAR_MD;
    walk_leap = cycle_leap(year);
    placed = 1'b0;
    for (int m = 1; m <= 12; m++) begin
      if (!placed) begin
        month_md = ((m % 2) == 1 || (m == 12 && walk_leap)) ? 30000 : 29000;
        if (rem < month_md) begin
          r.day = DAY_W'(rem / 1000 + 1);
          r.month = MONTH_W'(m);
          placed = 1'b1;
        end else begin
          rem -= month_md;
        end
      end
    end
    // remainder past the twelve months of a common year rolls into the next year
    if (!placed) begin
      year++;
      r.day = DAY_W'(1);
      r.month = MONTH_W'(1);
    end
    r.year = YEAR_W'(year);
    r.leap = cycle_leap(year);
    return r;
  endfunction

  always @(posedge clk) begin : track
    pending_date_t want;
    hijri_date_t   got;
    if (rst) begin
      expected_dates.delete();
      epoch_copy = EPOCH_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        want.jdn = julian_day_number;
        want.date = convert_day_number(julian_day_number, epoch_copy);
        expected_dates.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.day = hijri_day;
        got.month = hijri_month;
        got.year = hijri_year;
        got.leap = leap_year_flag;
        got.status = status_code;
        if (expected_dates.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%t: result with nothing pending: day %0d month %0d year %0d %s",
                     $realtime, got.day, got.month, got.year,
                     $sformatf("leap %0b status %0b", got.leap, got.status));
        end else begin
          want = expected_dates.pop_front();
          checked++;
          if (want.date.status) early++;
          if (got !== want.date) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $write("%t: day number %0d: expected day %0d month %0d year %0d leap %0b ",
                     $realtime, want.jdn, want.date.day, want.date.month, want.date.year,
                     want.date.leap);
              $display("status %0b, got day %0d month %0d year %0d leap %0b status %0b",
                       want.date.status, got.day, got.month, got.year, got.leap,
                       got.status);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) epoch_copy = epoch_day_number;
    end
    mismatch_count <= errors;
    pending_dates <= expected_dates.size();
    dates_checked <= checked;
    before_epoch_seen <= early;
  end

endmodule

// ===== test/hijri_date_from_day_number_tb.sv =====
// Testbench top for the Hijri date converter: clock, reset, epoch writes, day number
// stimulus and result-side stalls; the checker beside the block does the comparing.
// Depends on hijri_pkg, hijri_date_from_day_number and hijri_date_checker.
module hijri_date_from_day_number_tb
  import hijri_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 7;                    // register stages from item in to result out
  localparam int LONG_HOLD = 64;                 // receiver hold-off that fills the pipeline
  localparam int DRAIN_MARGIN = 3 * LATENCY;
  localparam logic [DN_W-1:0] DN_MAX = {DN_W{1'b1}};

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DN_W-1:0]    epoch_day_number = EPOCH_RESET;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DN_W-1:0]    julian_day_number = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DAY_W-1:0]   hijri_day;
  logic [MONTH_W-1:0] hijri_month;
  logic [YEAR_W-1:0]  hijri_year;
  logic               leap_year_flag;
  logic               status_code;

  int mismatch_count, pending_dates, dates_checked, before_epoch_seen;

  // Pacing knobs shared between the sender and the receiver processes.
  bit sender_quiet = 1'b0;   // no gaps between items while set
  bit sink_quiet = 1'b0;     // no stalls between results while set
  bit hold_request = 1'b0;   // ask the receiver for one long hold-off
  int items_sent = 0;
  int epochs_used = 1;       // the reset value counts as the first

  hijri_date_from_day_number DUT (.*);

  hijri_date_checker date_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("hijri_date_from_day_number_tb: errors");
    $finish;
  end

  // Offer one day number after a random gap, then hold it until the block takes it.
  // Valid stays high after acceptance so back-to-back items need no extra edge.
  task automatic offer_day(logic [DN_W-1:0] jdn);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    julian_day_number <= jdn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every pending date has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dates != 0) @(posedge clk);
  endtask

  // Write the epoch register; only called while the pipeline is empty.
  task automatic write_epoch(logic [DN_W-1:0] epoch);
    cfg_valid <= 1'b1;
    epoch_day_number <= epoch;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    epochs_used++;
  endtask

  // Draw a day number: mostly a short span past the epoch or a spot near a year
  // boundary, with some just before the epoch and some anywhere in the range.
  function automatic logic [DN_W-1:0] pick_day_number();
    int unsigned     pick;
    longint unsigned span, back;
    pick = $urandom_range(0, 99);
    if (pick < 20)
      return DN_W'($urandom);
    if (pick < 35 && epoch_day_number > 0) begin
      back = $urandom_range(1, (epoch_day_number > 400) ? 400 : epoch_day_number);
      return DN_W'(epoch_day_number - back);
    end
    if (pick < 65) begin
      // land on the first days of a year or the last of the one before
      span = (longint'($urandom_range(0, 11900)) * 354367) / 1000 + $urandom_range(0, 2);
      if (span > 0) span--;
    end else if (pick < 90) begin
      span = $urandom_range(0, 40000);
    end else begin
      span = $urandom_range(0, 4194303);
    end
    if (span + epoch_day_number > DN_MAX)
      return DN_W'($urandom);
    return DN_W'(epoch_day_number + span);
  endfunction

  // One block of random items; optionally pause partway until all dates are back.
  task automatic run_phase(int count, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i > 0 && i % 25 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      offer_day(pick_day_number());
      if (i == pause_at) settle();
    end
  endtask

  // Receiver: stall for a random number of cycles before each result, or for one
  // long stretch on request so the pipeline backs up into the input side.
  initial begin : result_sink
    int hold, taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = sink_quiet ? 0 : $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 40 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stimulus
    longint landmark_offsets[13] = '{-1, 0, 29, 30, 58, 59, 353, 354, 355, 708, 1062,
                                     10631, 10632};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset epoch: the day before the epoch, the epoch itself,
    // month edges, the fraction past a common year (year 1 and year 30 both roll
    // over to the 1st of month 1), the end of a leap year and the range extremes.
    offer_day('0);
    offer_day(DN_MAX);
    foreach (landmark_offsets[k])
      offer_day(DN_W'(longint'(epoch_day_number) + landmark_offsets[k]));

    // Epoch at zero: the whole input range is valid, the top reaches the largest year.
    settle();
    write_epoch('0);
    offer_day('0);
    offer_day(DN_W'(1));
    offer_day(DN_MAX);

    // Epoch at its maximum: only the top day number is on or after it.
    settle();
    write_epoch(DN_MAX);
    offer_day(DN_MAX);
    offer_day(DN_MAX - 1);

    // Random part, one phase per epoch setting.
    run_phase(60, -1);

    settle();
    write_epoch('0);
    sender_quiet = 1'b0;
    run_phase(120, 60);

    settle();
    write_epoch(DN_W'($urandom_range(0, 4194303)));
    run_phase(120, -1);

    // Back to the reset epoch under pressure: feed without gaps while the receiver
    // holds off, so the block fills and stalls its input.
    settle();
    write_epoch(EPOCH_RESET);
    sender_quiet = 1'b1;
    hold_request = 1'b1;
    run_phase(130, -1);

    settle();
    sender_quiet = 1'b0;
    write_epoch(DN_W'($urandom_range(0, 4000)));
    run_phase(120, -1);

    // Let everything drain, then give the block a few extra cycles to misbehave.
    settle();
    repeat (DRAIN_MARGIN) @(posedge clk);

    $display("covered %0d day numbers under %0d epoch settings", items_sent, epochs_used);
    $display("compared %0d dates, %0d of them before the epoch", dates_checked,
             before_epoch_seen);
    if (mismatch_count == 0 && pending_dates == 0) begin
      $display("hijri_date_from_day_number_tb: clean");
    end else begin
      $display("hijri_date_from_day_number_tb: errors");
    end
    $finish;
  end

endmodule
